[rtl/core/crdd_pkg.sv]
// Shared types and constants for the CSR row diagonal dominance block.
`default_nettype none

package crdd_pkg;

    localparam int INDEX_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COEF_BITS      = 32;
    localparam int SUM_BITS       = 48;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // ratio bounds as magnitudes, one bit wider than the result word
    localparam logic [COEF_BITS:0] LIMIT_POS = {2'b00, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS:0] LIMIT_NEG = {2'b01, {(COEF_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NODIAG_POS = 2'd1,
        STATUS_NODIAG_NEG = 2'd2,
        STATUS_SAT        = 2'd3
    } crdd_status_t;

    typedef enum logic {
        S_ACCUM = 1'b0,
        S_DIV   = 1'b1
    } crdd_state_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } crdd_div_stat_t;

endpackage

`default_nettype wire

[rtl/core/crdd_div.sv]
// Restoring divider, one quotient bit per cycle, with a sticky overflow above 33 bits.
`default_nettype none

module crdd_div
    import crdd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [SUM_BITS-1:0]   num,
    input  wire logic [COEF_BITS-1:0]  den,
    output logic [COEF_BITS:0]         quot,
    output crdd_div_stat_t             stat
);

    localparam int NW = SUM_BITS + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [CW-1:0] STEPS = CW'(NW);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic [NW-1:0]        num_reg;
    logic [COEF_BITS-1:0] den_reg;
    logic [COEF_BITS-1:0] rem_reg;
    logic [COEF_BITS:0]   quo_reg;
    logic                 ovf_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [COEF_BITS:0]   trial;
    logic                 ge;
    logic [COEF_BITS:0]   diff;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ONE;
                if (cnt_reg == ONE)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {num, {FRAC_BITS{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            // remainder stays below den, so it always fits the word
            rem_reg <= ge ? diff[COEF_BITS-1:0] : trial[COEF_BITS-1:0];
            quo_reg <= {quo_reg[COEF_BITS-1:0], ge};
            ovf_reg <= ovf_reg | quo_reg[COEF_BITS];
        end
    end

    assign quot      = quo_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

`default_nettype wire

[rtl/core/csr_row_diag_dominance_top.sv]
// Top level: per-row diagonal dominance ratio of CSR matrix entries.
//
// Input channel (in_valid/in_stall) takes one nonzero entry per beat in row
// order; row_last marks the row's closing beat, holds_entry = 0 carries no entry.
// Non-closing beats enter a 48-bit saturating sum one per cycle between divisions.
// A closing beat with no nonzero diagonal has its result registered next cycle.
// A closing beat with a diagonal starts the shared restoring divider, one
// quotient bit per cycle over 48 + FRAC_BITS bits (64 at default), and the
// result is registered when the divider signals done; in_stall is high
// during the division.
// Output channel (out_valid/out_stall) is a single result register. Entry
// beats keep flowing while a result waits; outside a division, a closing beat
// is held off only while the output register is full and stalled.
// Reset clears the running sum, the diagonal, the sequencer and out_valid.
`default_nettype none

module csr_row_diag_dominance_top
    import crdd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [INDEX_BITS-1:0]        row,
    input  wire logic [INDEX_BITS-1:0]        column,
    input  wire logic signed [COEF_BITS-1:0]  coefficient,
    input  wire logic                         holds_entry,
    input  wire logic                         row_last,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [INDEX_BITS-1:0]             result_row,
    output logic signed [COEF_BITS-1:0]       dominance,
    output logic [1:0]                        status
);

    crdd_state_t state_reg, state_next;

    logic signed [SUM_BITS-1:0] sum_reg;
    logic [COEF_BITS-1:0]       diag_reg;
    logic                       neg_reg;
    logic [INDEX_BITS-1:0]      row_reg;

    logic                       out_valid_reg;
    logic [INDEX_BITS-1:0]      result_row_reg;
    logic signed [COEF_BITS-1:0] dominance_reg;
    crdd_status_t               status_reg;

    logic                       accept;
    logic                       is_diag;
    logic [COEF_BITS-1:0]       mag;
    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_sat;
    logic signed [SUM_BITS-1:0] eff_sum;
    logic [COEF_BITS-1:0]       eff_diag;
    logic                       eff_neg;
    logic [SUM_BITS-1:0]        abs_sum;
    logic                       div_start;
    logic                       load_nodiag;

    logic [COEF_BITS:0]         quot;
    crdd_div_stat_t             div_stat;
    logic [COEF_BITS:0]         limit;
    logic                       over;
    logic [COEF_BITS-1:0]       mq;

    // entry magnitude; the most negative word maps to 2^31 as unsigned
    assign mag     = coefficient[COEF_BITS-1] ? (~coefficient + 1'b1) : coefficient;
    assign is_diag = column == row;

    assign sum_wide = is_diag ? ({sum_reg[SUM_BITS-1], sum_reg}
                                 + $signed({{(SUM_BITS+1-COEF_BITS){1'b0}}, mag}))
                              : ({sum_reg[SUM_BITS-1], sum_reg}
                                 - $signed({{(SUM_BITS+1-COEF_BITS){1'b0}}, mag}));

    always_comb
    begin
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
            sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[SUM_BITS-1:0];
    end

    assign eff_sum  = holds_entry ? sum_sat : sum_reg;
    assign eff_diag = (holds_entry && is_diag) ? mag : diag_reg;
    assign eff_neg  = eff_sum[SUM_BITS-1];
    assign abs_sum  = eff_neg ? SUM_BITS'(-eff_sum) : SUM_BITS'(eff_sum);

    assign accept      = in_valid && !in_stall;
    assign div_start   = accept && row_last && (eff_diag != '0);
    assign load_nodiag = accept && row_last && (eff_diag == '0);

    crdd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (abs_sum),
        .den   (eff_diag),
        .quot  (quot),
        .stat  (div_stat)
    );

    assign limit = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign over  = div_stat.ovf || (quot > limit);
    assign mq    = over ? limit[COEF_BITS-1:0] : quot[COEF_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_ACCUM;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_ACCUM:
            begin
                in_stall = row_last && out_valid_reg && out_stall;
                if (div_start)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_ACCUM;
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            diag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (row_last)
                begin
                    sum_reg  <= '0;
                    diag_reg <= '0;
                end
                else
                begin
                    sum_reg  <= eff_sum;
                    diag_reg <= eff_diag;
                end
            end
            if (load_nodiag || div_stat.done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            neg_reg <= eff_neg;
            row_reg <= row;
        end
        if (load_nodiag)
        begin
            result_row_reg <= row;
            dominance_reg  <= '0;
            status_reg     <= eff_neg ? STATUS_NODIAG_NEG : STATUS_NODIAG_POS;
        end
        else if (div_stat.done)
        begin
            result_row_reg <= row_reg;
            dominance_reg  <= neg_reg ? $signed(-mq) : $signed(mq);
            status_reg     <= over ? STATUS_SAT : STATUS_OK;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_row = result_row_reg;
    assign dominance  = dominance_reg;
    assign status     = status_reg;

    // divider only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider done outside division state");

    // output slot is free for the whole division
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !out_valid_reg)
        else $error("output register busy during division");

    // rows without a diagonal report a zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_NODIAG_POS
                           || status_reg == STATUS_NODIAG_NEG)) |-> dominance_reg == '0)
        else $error("nonzero ratio without diagonal");

endmodule

`default_nettype wire
